FILE: rtl/scn_pkg.sv
`timescale 1ns / 1ps

package scn_pkg;

  // Widths fixed by the field definitions.
  localparam int ACTION_W = 2;
  localparam int OUT_W    = 12;
  localparam int NUM_AXES = 4;

  // Defaults for the top-level parameters.
  localparam int LEVEL_MAX_DEF = 1000;
  localparam int LEVEL_MIN_DEF = -1000;
  localparam int RAW_WIDTH_DEF = 11;

  // The level span is cut into eighths before scaling, and the quotient
  // is multiplied back by the same factor.
  localparam int SCALE_DIV   = 8;
  localparam int SCALE_SHIFT = 3;

  // Axis slots in the calibration store.
  localparam logic [1:0] AXIS_X     = 2'd0;
  localparam logic [1:0] AXIS_Y     = 2'd1;
  localparam logic [1:0] AXIS_PITCH = 2'd2;
  localparam logic [1:0] AXIS_ROLL  = 2'd3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NORMALIZE = 2'd0,
    ACT_CAPTURE   = 2'd1,
    ACT_WIDEN     = 2'd2
  } action_e;

endpackage

FILE: rtl/scn_if.sv
`timescale 1ns / 1ps

// Request channel carrying one set of raw stick readings.
interface scn_in_if import scn_pkg::*; #(
  parameter int RAW_WIDTH = RAW_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic [ACTION_W-1:0]         action;
  logic signed [RAW_WIDTH-1:0] joy_x;
  logic signed [RAW_WIDTH-1:0] joy_y;
  logic signed [RAW_WIDTH-1:0] pitch_reading;
  logic signed [RAW_WIDTH-1:0] roll_reading;

  modport source (
    output valid, action, joy_x, joy_y, pitch_reading, roll_reading,
    input  ready
  );
  modport sink (
    input  valid, action, joy_x, joy_y, pitch_reading, roll_reading,
    output ready
  );
endinterface

// Result channel carrying the four normalized channels.
interface scn_out_if import scn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] channel_zero;
  logic signed [OUT_W-1:0] channel_one;
  logic signed [OUT_W-1:0] channel_two;
  logic signed [OUT_W-1:0] channel_three;

  modport source (
    output valid, channel_zero, channel_one, channel_two, channel_three,
    input  ready
  );
  modport sink (
    input  valid, channel_zero, channel_one, channel_two, channel_three,
    output ready
  );
endinterface

FILE: rtl/scn_serial_div.sv
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module scn_serial_div import scn_pkg::*; #(
  parameter int NUM_W = RAW_WIDTH_DEF + 9,
  parameter int DEN_W = RAW_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    trial   = shifted - {1'b0, den_q};
    fits    = shifted >= {1'b0, den_q};

    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;

    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/scn_cal_store.sv
`timescale 1ns / 1ps

// Per-axis zero point and calibrated range.
module scn_cal_store import scn_pkg::*; #(
  parameter int RAW_WIDTH = RAW_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        commit_i,
  input  logic [ACTION_W-1:0]         action_i,
  input  logic signed [RAW_WIDTH-1:0] rd_i [NUM_AXES],
  input  logic [1:0]                  sel_i,
  output logic signed [RAW_WIDTH-1:0] zero_o,
  output logic signed [RAW_WIDTH-1:0] low_o,
  output logic signed [RAW_WIDTH-1:0] high_o
);

  logic signed [RAW_WIDTH-1:0] zero_q [NUM_AXES];
  logic signed [RAW_WIDTH-1:0] low_q  [NUM_AXES];
  logic signed [RAW_WIDTH-1:0] high_q [NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        zero_q[i] <= '0;
        low_q[i]  <= '0;
        high_q[i] <= '0;
      end
    end else if (commit_i) begin
      case (action_i)
        ACT_CAPTURE: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            zero_q[i] <= rd_i[i];
            low_q[i]  <= rd_i[i];
            high_q[i] <= rd_i[i];
          end
        end
        ACT_WIDEN: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            if (rd_i[i] < low_q[i]) low_q[i] <= rd_i[i];
            if (rd_i[i] > high_q[i]) high_q[i] <= rd_i[i];
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign zero_o = zero_q[sel_i];
  assign low_o  = low_q[sel_i];
  assign high_o = high_q[sel_i];

endmodule

FILE: rtl/stick_axis_calibrate_normalize_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload
// in_i      in   in_i.valid / in_i.ready   action, joy_x, joy_y, pitch_reading, roll_reading
// out_o     out  out_o.valid / out_o.ready channel_zero .. channel_three
// cfg       in   cfg_we_i (no wait)        cfg_wdata_i -> stick_mode_two
//
// Requests are taken only while the block is idle; NUM_W = RAW_WIDTH + bits of the
// level step (19 at the defaults). Each axis runs through a setup state, the
// bit-serial divider and a post state; a done and an idle state follow the last axis.
// The bit-serial divider sets the rate.
// Reset clears the calibration store, the mode register and all handshake state.
// A finished result waits in the output register while the next request is taken;
// the block stalls only if a second result is done before the first one is taken.

module stick_axis_calibrate_normalize_top import scn_pkg::*; #(
  parameter int LEVEL_MAX = LEVEL_MAX_DEF,
  parameter int LEVEL_MIN = LEVEL_MIN_DEF,
  parameter int RAW_WIDTH = RAW_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  scn_in_if.sink    in_i,
  scn_out_if.source out_o
);

  // Level step per eighth of the span, and the derived datapath widths.
  localparam int STEP   = (LEVEL_MAX - LEVEL_MIN) / SCALE_DIV;
  localparam int STEP_W = $clog2(STEP + 1);
  localparam int NUM_W  = RAW_WIDTH + STEP_W;
  localparam int DIFF_W = RAW_WIDTH + 1;
  localparam int EXT_W  = ((RAW_WIDTH + 1) > OUT_W) ? (RAW_WIDTH + 2) : (OUT_W + 1);
  localparam int QS_W   = OUT_W - SCALE_SHIFT;
  // Largest quotient magnitudes that survive the clamp after the times-eight.
  localparam int QPOS   = LEVEL_MAX / SCALE_DIV;
  localparam int QNEG   = (-LEVEL_MIN) / SCALE_DIV;

  localparam logic signed [EXT_W-1:0] LMAX_E = EXT_W'(LEVEL_MAX);
  localparam logic signed [EXT_W-1:0] LMIN_E = EXT_W'(LEVEL_MIN);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SETUP = 5'b00010,
    S_DIV   = 5'b00100,
    S_POST  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic       mode_q;
  logic       out_valid_q, out_valid_d;

  // Latched request; payload registers carry no reset.
  logic signed [RAW_WIDTH-1:0] rd_q [NUM_AXES];
  logic [ACTION_W-1:0]         action_q;

  // Per-axis operand flags captured at setup.
  logic                        neg_q;
  logic                        empty_q;
  logic signed [RAW_WIDTH-1:0] lo_q;

  logic signed [OUT_W-1:0] ch_q [NUM_AXES];
  logic signed [OUT_W-1:0] out_ch_q [NUM_AXES];

  logic signed [RAW_WIDTH-1:0] cal_zero, cal_low, cal_high;
  logic signed [RAW_WIDTH-1:0] rd_sel;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [DIFF_W-1:0]    span;
  logic [RAW_WIDTH-1:0]        mag;
  logic [NUM_W-1:0]            num;
  logic [RAW_WIDTH-1:0]        den;

  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] quo;

  logic signed [EXT_W-1:0] q8;
  logic signed [EXT_W-1:0] val;
  logic signed [EXT_W-1:0] val_axis;

  logic accept;
  logic out_free;
  logic commit;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign commit   = state_q == S_DONE && out_free;
  assign in_i.ready = state_q == S_IDLE;

  // The calibration store is read at the axis under work and written only
  // once the result has been handed over, so results see the old state.
  scn_cal_store #(
    .RAW_WIDTH(RAW_WIDTH)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .action_i (action_q),
    .rd_i     (rd_q),
    .sel_i    (axis_q),
    .zero_o   (cal_zero),
    .low_o    (cal_low),
    .high_o   (cal_high)
  );

  // Operand setup: magnitude of the offset reading times the level step,
  // divided by the calibrated span, which is never negative.
  always_comb begin
    rd_sel = rd_q[axis_q];
    diff   = $signed({rd_sel[RAW_WIDTH-1], rd_sel}) -
             $signed({cal_zero[RAW_WIDTH-1], cal_zero});
    mag    = diff[DIFF_W-1] ? RAW_WIDTH'(-diff) : diff[RAW_WIDTH-1:0];
    num    = NUM_W'(mag) * NUM_W'(STEP);
    span   = $signed({cal_high[RAW_WIDTH-1], cal_high}) -
             $signed({cal_low[RAW_WIDTH-1], cal_low});
    den    = span[RAW_WIDTH-1:0];
  end

  assign div_start = state_q == S_SETUP;

  scn_serial_div #(
    .NUM_W(NUM_W),
    .DEN_W(RAW_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num),
    .divisor_i  (den),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Post-processing: restore the sign, scale by eight and clamp. An empty
  // range bypasses scaling and returns the stored minimum. Pitch is negated.
  always_comb begin
    q8 = EXT_W'({quo[QS_W-1:0], {SCALE_SHIFT{1'b0}}});
    if (empty_q) begin
      val = $signed({{(EXT_W-RAW_WIDTH){lo_q[RAW_WIDTH-1]}}, lo_q});
    end else if (neg_q) begin
      val = (quo > NUM_W'(QNEG)) ? LMIN_E : -q8;
    end else begin
      val = (quo > NUM_W'(QPOS)) ? LMAX_E : q8;
    end
    val_axis = (axis_q == AXIS_PITCH) ? -val : val;
  end

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          axis_d  = '0;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_d = S_POST;
      end
      S_POST: begin
        axis_d  = axis_q + 1'b1;
        state_d = (axis_q == AXIS_ROLL) ? S_DONE : S_SETUP;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q[AXIS_X]     <= in_i.joy_x;
      rd_q[AXIS_Y]     <= in_i.joy_y;
      rd_q[AXIS_PITCH] <= in_i.pitch_reading;
      rd_q[AXIS_ROLL]  <= in_i.roll_reading;
      action_q         <= in_i.action;
    end
    if (state_q == S_SETUP) begin
      neg_q   <= diff[DIFF_W-1];
      empty_q <= cal_low == cal_high;
      lo_q    <= cal_low;
    end
    if (state_q == S_POST) begin
      ch_q[axis_q] <= val_axis[OUT_W-1:0];
    end
    // With mode two clear, the outer and the inner channel pairs swap.
    if (commit) begin
      if (mode_q) begin
        out_ch_q[0] <= ch_q[AXIS_X];
        out_ch_q[1] <= ch_q[AXIS_PITCH];
        out_ch_q[2] <= ch_q[AXIS_Y];
        out_ch_q[3] <= ch_q[AXIS_ROLL];
      end else begin
        out_ch_q[0] <= ch_q[AXIS_ROLL];
        out_ch_q[1] <= ch_q[AXIS_Y];
        out_ch_q[2] <= ch_q[AXIS_PITCH];
        out_ch_q[3] <= ch_q[AXIS_X];
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.channel_zero  = out_ch_q[0];
  assign out_o.channel_one   = out_ch_q[1];
  assign out_o.channel_two   = out_ch_q[2];
  assign out_o.channel_three = out_ch_q[3];

`ifndef NO_ASSERTIONS
  // The divider only finishes while the sequencer is waiting for it.
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  // The axis counter wraps back to the first axis after every request.
  a_axis_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> axis_q == AXIS_X)
    else $error("axis counter not at the first axis while idle");

  // The calibrated range never inverts, so the divisor is never negative.
  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_high >= cal_low)
    else $error("calibrated maximum below minimum");

  // State is committed only in the same cycle a result is loaded.
  a_commit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q && state_q == S_IDLE)
    else $error("commit without a result being loaded");
`endif

endmodule

FILE: dv/stick_axis_calibrate_normalize_top_tb.sv
`timescale 1ns / 1ps

localparam int RAW_W    = scn_pkg::RAW_WIDTH_DEF;
localparam int CH_W     = scn_pkg::OUT_W;
localparam int LVL_MAX  = scn_pkg::LEVEL_MAX_DEF;
localparam int LVL_MIN  = scn_pkg::LEVEL_MIN_DEF;
localparam int LVL_STEP = (LVL_MAX - LVL_MIN) / scn_pkg::SCALE_DIV;

// The action field is two bits wide, but only three codes are defined.
localparam logic [scn_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

typedef logic signed [RAW_W-1:0] reading_t;
typedef logic signed [CH_W-1:0]  level_t;

typedef struct packed {
  level_t ch_zero;
  level_t ch_one;
  level_t ch_two;
  level_t ch_three;
} channels_t;

class stick_calib_scoreboard;
  bit          mode_two;
  reading_t    zero_pt  [4];
  reading_t    range_lo [4];
  reading_t    range_hi [4];
  channels_t   expected_channels [$];
  int unsigned mismatches;

  function new();
    mode_two   = 1'b0;
    mismatches = 0;
    for (int a = 0; a < 4; a++) begin
      zero_pt[a]  = '0;
      range_lo[a] = '0;
      range_hi[a] = '0;
    end
  endfunction

  // Scales one reading against the calibration of its axis.
  function int scale_reading(reading_t reading, int axis);
    int lo;
    int hi;
    int q;
    lo = range_lo[axis];
    hi = range_hi[axis];
    if (lo == hi) return lo;
    q = ((int'(reading) - int'(zero_pt[axis])) * LVL_STEP) / (hi - lo);
    q = q * scn_pkg::SCALE_DIV;
    if (q > LVL_MAX) q = LVL_MAX;
    if (q < LVL_MIN) q = LVL_MIN;
    return q;
  endfunction

  function void note_request(logic [scn_pkg::ACTION_W-1:0] action,
                             reading_t x, reading_t y, reading_t p, reading_t r);
    reading_t  rd [4];
    int        ch [4];
    channels_t predicted;
    rd[scn_pkg::AXIS_X]     = x;
    rd[scn_pkg::AXIS_Y]     = y;
    rd[scn_pkg::AXIS_PITCH] = p;
    rd[scn_pkg::AXIS_ROLL]  = r;
    ch[0] = scale_reading(x, scn_pkg::AXIS_X);
    ch[1] = -scale_reading(p, scn_pkg::AXIS_PITCH);
    ch[2] = scale_reading(y, scn_pkg::AXIS_Y);
    ch[3] = scale_reading(r, scn_pkg::AXIS_ROLL);
    if (mode_two) begin
      predicted.ch_zero  = level_t'(ch[0]);
      predicted.ch_one   = level_t'(ch[1]);
      predicted.ch_two   = level_t'(ch[2]);
      predicted.ch_three = level_t'(ch[3]);
    end else begin
      predicted.ch_zero  = level_t'(ch[3]);
      predicted.ch_one   = level_t'(ch[2]);
      predicted.ch_two   = level_t'(ch[1]);
      predicted.ch_three = level_t'(ch[0]);
    end
    expected_channels.push_back(predicted);

    // The outputs above use the calibration from before this request.
    case (action)
      scn_pkg::ACT_CAPTURE: begin
        for (int a = 0; a < 4; a++) begin
          zero_pt[a]  = rd[a];
          range_lo[a] = rd[a];
          range_hi[a] = rd[a];
        end
      end
      scn_pkg::ACT_WIDEN: begin
        for (int a = 0; a < 4; a++) begin
          if (rd[a] < range_lo[a]) range_lo[a] = rd[a];
          if (rd[a] > range_hi[a]) range_hi[a] = rd[a];
        end
      end
      default: ;
    endcase
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task compare_field(string name, level_t got, level_t want);
    if (got !== want)
      report($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task check_result(channels_t got);
    channels_t want;
    if (expected_channels.size() == 0) begin
      report("result arrived with no request outstanding");
      return;
    end
    want = expected_channels.pop_front();
    compare_field("channel_zero",  got.ch_zero,  want.ch_zero);
    compare_field("channel_one",   got.ch_one,   want.ch_one);
    compare_field("channel_two",   got.ch_two,   want.ch_two);
    compare_field("channel_three", got.ch_three, want.ch_three);
  endtask
endclass

module stick_axis_calibrate_normalize_top_tb;
  import scn_pkg::*;

  // The run is about 1800 requests, under 2 ms even with the longest gaps on both
  // sides; this allows ten times that.
  localparam longint TIMEOUT_NS   = 20_000_000;
  // A little more than one request needs inside the block; waited at the end.
  localparam int     DRAIN_CYCLES = 150;
  localparam int     PHASE_ITEMS  = 450;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  // Cleared for short stretches so that both sides also run back to back.
  bit          idle_on = 1'b1;
  int unsigned items_sent = 0;

  stick_calib_scoreboard calib_sb;

  scn_in_if #(.RAW_WIDTH(RAW_W)) in_if ();
  scn_out_if                     out_if ();

  stick_axis_calibrate_normalize_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #4 clk_i = ~clk_i;

  // Drives one request and waits for the block to take it. A gap of zero keeps
  // valid high from the previous request, so valid only ever gets one update
  // per clock edge. The request is handed to the scoreboard once accepted.
  task automatic send_readings(input logic [ACTION_W-1:0] action,
                               input int x, input int y, input int p, input int r);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.action        <= action;
    in_if.joy_x         <= reading_t'(x);
    in_if.joy_y         <= reading_t'(y);
    in_if.pitch_reading <= reading_t'(p);
    in_if.roll_reading  <= reading_t'(r);
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    calib_sb.note_request(action, reading_t'(x), reading_t'(y), reading_t'(p),
                          reading_t'(r));
    items_sent++;
  endtask

  // Readings lean toward the rails and toward a small band around zero, so
  // both clamping and narrow calibration ranges come up often.
  function automatic int pick_reading();
    case ($urandom_range(0, 7))
      0:       return -1024;
      1:       return 1023;
      2, 3:    return int'($urandom_range(0, 40)) - 20;
      default: return int'($urandom_range(0, 2047)) - 1024;
    endcase
  endfunction

  // Most sessions follow the real use: capture the rest position, widen the
  // range a few times, then normalize. The rest is random actions as noise.
  task automatic run_session();
    int unsigned        n;
    logic [ACTION_W-1:0] act;
    idle_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 9) < 8) begin
      send_readings(ACT_CAPTURE, pick_reading(), pick_reading(), pick_reading(),
                    pick_reading());
      n = $urandom_range(0, 6);
      repeat (n)
        send_readings(ACT_WIDEN, pick_reading(), pick_reading(), pick_reading(),
                      pick_reading());
      n = $urandom_range(3, 25);
      repeat (n) begin
        act = ($urandom_range(0, 15) == 0) ? ACT_UNUSED : ACT_NORMALIZE;
        send_readings(act, pick_reading(), pick_reading(), pick_reading(),
                      pick_reading());
      end
    end else begin
      n = $urandom_range(2, 8);
      repeat (n) begin
        act = ACTION_W'($urandom_range(0, 3));
        send_readings(act, pick_reading(), pick_reading(), pick_reading(),
                      pick_reading());
      end
    end
  endtask

  task automatic run_random_phase(input int unsigned count);
    int unsigned first;
    first = items_sent;
    while (items_sent - first < count) run_session();
  endtask

  // Every request yields exactly one result, so the block is idle once the
  // scoreboard holds no more expectations.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (calib_sb.expected_channels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    calib_sb.mode_two = value;
  endtask

  // Result side: stall a random number of cycles before each result, then
  // hold ready until a result is taken and check it.
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      calib_sb.check_result('{out_if.channel_zero, out_if.channel_one,
                              out_if.channel_two, out_if.channel_three});
    end
  end

  initial begin
    calib_sb            = new();
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_wdata_i         = 1'b0;
    in_if.valid         = 1'b0;
    in_if.action        = ACT_NORMALIZE;
    in_if.joy_x         = '0;
    in_if.joy_y         = '0;
    in_if.pitch_reading = '0;
    in_if.roll_reading  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, in the reset mode where the channel pairs are swapped.
    // Right after reset every range is empty, so all channels read zero.
    send_readings(ACT_NORMALIZE, 0, 0, 0, 0);
    send_readings(ACT_NORMALIZE, -1024, 1023, -1, 1);
    // The undefined action code changes nothing.
    send_readings(ACT_UNUSED, 1023, -1024, 1023, -1024);
    // Capture at the bottom rail; the next request still sees an empty range
    // and returns the stored minimum, with the pitch channel negated to 1024.
    send_readings(ACT_CAPTURE, -1024, -1024, -1024, -1024);
    send_readings(ACT_NORMALIZE, 1023, 1023, 1023, 1023);
    // Widen to the full span, then sample both rails and the middle.
    send_readings(ACT_WIDEN, 1023, 1023, 1023, 1023);
    send_readings(ACT_NORMALIZE, -1024, -1024, -1024, -1024);
    send_readings(ACT_NORMALIZE, 1023, 1023, 1023, 1023);
    send_readings(ACT_NORMALIZE, 0, 0, 0, 0);
    // A range one step wide makes the quotient far exceed the level range,
    // which must clamp rather than wrap.
    send_readings(ACT_CAPTURE, 0, 0, 0, 0);
    send_readings(ACT_WIDEN, 1, -1, 1, -1);
    send_readings(ACT_NORMALIZE, 1023, -1024, 1023, -1024);
    send_readings(ACT_NORMALIZE, -1024, 1023, -1024, 1023);
    send_readings(ACT_WIDEN, 0, 0, 0, 0);
    // An off-center rest position, with the roll range left empty so that
    // one axis passes its stored minimum through while the others scale.
    send_readings(ACT_CAPTURE, 5, -7, 300, -300);
    send_readings(ACT_WIDEN, 100, -200, 5, -300);
    send_readings(ACT_NORMALIZE, 37, -150, -5, 1023);
    // Small negative offsets check that the division truncates toward zero.
    send_readings(ACT_NORMALIZE, -3, -6, 299, -1);
    send_readings(ACT_UNUSED, 1023, 1023, -1024, -1024);
    send_readings(ACT_WIDEN, 1023, -1024, -1024, 1023);
    send_readings(ACT_NORMALIZE, -683, 682, -683, 682);
    send_readings(ACT_NORMALIZE, 682, -683, 682, -683);
    drain();

    // Random part, alternating the channel order between phases.
    write_mode(1'b1);
    run_random_phase(PHASE_ITEMS);
    drain();
    write_mode(1'b0);
    run_random_phase(PHASE_ITEMS);
    drain();
    write_mode(1'b1);
    run_random_phase(PHASE_ITEMS);
    drain();
    write_mode(1'b0);
    run_random_phase(PHASE_ITEMS);
    drain();

    // Leave time for any stray result to show up before deciding.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (calib_sb.mismatches == 0 && calib_sb.expected_channels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
rtl/scn_pkg.sv
rtl/scn_if.sv
rtl/scn_serial_div.sv
rtl/scn_cal_store.sv
rtl/stick_axis_calibrate_normalize_top.sv
dv/stick_axis_calibrate_normalize_top_tb.sv
